// ===== rtl/imhq_pkg.sv =====
`default_nettype none
package imhq_pkg;

    localparam int KeyW    = 8;
    localparam int WeightW = 32;
    localparam int StatusW = 3;
    localparam int CountW  = 9;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_CHANGE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_IGNORED = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [KeyW-1:0]           item_key;
        logic signed [WeightW-1:0] item_weight;
    } request_t;

    typedef struct packed {
        logic [StatusW-1:0]        status;
        logic [KeyW-1:0]           popped_key;
        logic signed [WeightW-1:0] popped_weight;
        logic [CountW-1:0]         entry_count;
        logic                      is_empty;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/indexed_min_heap_queue.sv =====
// Channel  | Direction | Handshake          | Payload
// request  | in        | start & !busy      | request_t
// result   | out       | done (one cycle)   | result_t
//
// A push or a change of weight reads the key position and then its slot, then for each
// level that the entry sifts up reads the parent, compares and writes; a pop reads the
// top and moves the last entry into it, then for each level sifted down reads the
// children, compares and writes the best child up.
// Reset clears the control state and the entry count; memories are not cleared,
// as presence is checked by the position cross-check and slots below the count.
// busy is high from acceptance until done; the receiver cannot stall results.
`default_nettype none
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam int PosW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int KeySpace = 1 << KeyW;

    typedef enum logic [4:0] {
        S_IDLE, S_KP_RD, S_KP_WAIT, S_SLOT_RD, S_SLOT_WAIT, S_DECIDE,
        S_PUSH_WR, S_UP_RD, S_UP_WAIT, S_UP_CMP, S_UP_WR2,
        S_POP_RD_LAST, S_POP_WAIT_LAST, S_POP_WR0,
        S_DN_RDL, S_DN_WAITL, S_DN_RDR, S_DN_WAITR, S_DN_CMP, S_DN_WR2,
        S_DONE
    } state_t;

    // Heap slot and key-position memories.
    logic [KeyW-1:0]    slot_key_mem [CAPACITY];
    logic [WeightW-1:0] slot_wt_mem  [CAPACITY];
    logic [PosW-1:0]    key_pos_mem  [KeySpace];

    state_t              state_reg;
    logic [CntW-1:0]     count_reg;
    logic [1:0]          req_reg;
    logic [KeyW-1:0]     key_reg;
    logic [WeightW-1:0]  wt_reg;
    logic [StatusW-1:0]  status_reg;
    logic [KeyW-1:0]     pk_reg;
    logic [WeightW-1:0]  pw_reg;
    logic                done_reg;
    // Current entry being sifted and its position.
    logic [PosW-1:0]     pos_reg;
    logic [KeyW-1:0]     cur_key_reg;
    logic [WeightW-1:0]  cur_wt_reg;
    // Other entry read from the slot port.
    logic [PosW-1:0]     oth_pos_reg;
    logic [KeyW-1:0]     oth_key_reg;
    logic [WeightW-1:0]  oth_wt_reg;
    logic                best_valid_reg;
    logic [PosW-1:0]     kp_reg;

    // Single-port control of the slot and key-position memories, driven by the sequencer.
    logic [PosW-1:0]     s_addr;
    logic                s_we;
    logic [KeyW-1:0]     s_wkey;
    logic [WeightW-1:0]  s_wwt;
    logic [KeyW-1:0]     s_rkey_reg;
    logic [WeightW-1:0]  s_rwt_reg;
    logic                k_we;
    logic [KeyW-1:0]     k_addr;
    logic [PosW-1:0]     k_wdata;
    logic [PosW-1:0]     k_rdata_reg;

    // Shared compare unit: signed less-than.
    logic [WeightW-1:0] cmp_a, cmp_b;
    logic               cmp_lt;
    assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

    // Child and parent index arithmetic, one bit wider than the count.
    logic [CntW:0] left_idx, right_idx, parent_idx;
    assign left_idx   = {pos_reg, 1'b1} + (CntW + 1)'(0);
    assign right_idx  = left_idx + (CntW + 1)'(1);
    assign parent_idx = (CntW + 1)'((pos_reg - PosW'(1)) >> 1);

    logic full_w, present_w;
    assign full_w    = CntW'(count_reg) >= CntW'(CAPACITY);
    assign present_w = ((CntW)'(kp_reg) < count_reg) && (s_rkey_reg == key_reg);

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            slot_key_mem[s_addr] <= s_wkey;
            slot_wt_mem[s_addr]  <= s_wwt;
        end
        s_rkey_reg <= slot_key_mem[s_addr];
        s_rwt_reg  <= slot_wt_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            key_pos_mem[k_addr] <= k_wdata;
        end
        k_rdata_reg <= key_pos_mem[k_addr];
    end

    // Memory port and compare selection by state.
    always_comb
    begin
        s_addr  = pos_reg;
        s_we    = 1'b0;
        s_wkey  = cur_key_reg;
        s_wwt   = cur_wt_reg;
        k_we    = 1'b0;
        k_addr  = key_reg;
        k_wdata = pos_reg;
        cmp_a   = cur_wt_reg;
        cmp_b   = oth_wt_reg;
        unique case (state_reg)
            S_SLOT_RD, S_SLOT_WAIT:
            begin
                s_addr = kp_reg;
            end
            S_PUSH_WR:
            begin
                s_we    = 1'b1;
                k_we    = 1'b1;
                k_addr  = cur_key_reg;
            end
            S_UP_RD:
            begin
                s_addr = PosW'(parent_idx);
            end
            S_UP_CMP:
            begin
                // Parent moves down into the current position.
                s_we    = cmp_lt;
                s_wkey  = oth_key_reg;
                s_wwt   = oth_wt_reg;
                k_we    = cmp_lt;
                k_addr  = oth_key_reg;
            end
            S_UP_WR2:
            begin
                s_we    = 1'b1;
                k_we    = 1'b1;
                k_addr  = cur_key_reg;
            end
            S_POP_RD_LAST:
            begin
                // The count has already dropped, so it indexes the last entry.
                s_addr = PosW'(count_reg);
            end
            S_POP_WR0:
            begin
                s_we    = 1'b1;
                k_we    = 1'b1;
                k_addr  = cur_key_reg;
            end
            S_DN_RDL:
            begin
                s_addr = PosW'(left_idx);
            end
            S_DN_RDR:
            begin
                s_addr = PosW'(right_idx);
            end
            S_DN_WAITR:
            begin
                cmp_a = s_rwt_reg;
                cmp_b = best_valid_reg ? oth_wt_reg : cur_wt_reg;
            end
            S_DN_WAITL:
            begin
                cmp_a = s_rwt_reg;
                cmp_b = cur_wt_reg;
            end
            S_DN_CMP:
            begin
                // Best child moves up into the current position.
                s_we    = best_valid_reg;
                s_wkey  = oth_key_reg;
                s_wwt   = oth_wt_reg;
                k_we    = best_valid_reg;
                k_addr  = oth_key_reg;
            end
            S_DN_WR2:
            begin
                s_we    = 1'b1;
                k_we    = 1'b1;
                k_addr  = cur_key_reg;
            end
            S_DECIDE:
            begin
                cmp_a = wt_reg;
                cmp_b = s_rwt_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer with registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            pk_reg     <= '0;
            pw_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !done_reg)
                    begin
                        req_reg    <= request.req_type;
                        key_reg    <= request.item_key;
                        wt_reg     <= request.item_weight;
                        status_reg <= ST_OK;
                        pk_reg     <= '0;
                        pw_reg     <= '0;
                        priority case (request.req_type)
                            REQ_POP:
                            begin
                                if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    pos_reg   <= '0;
                                    state_reg <= S_SLOT_RD;
                                    kp_reg    <= '0;
                                end
                            end
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_KP_RD;
                            end
                        endcase
                    end
                end
                S_KP_RD:
                begin
                    state_reg <= S_KP_WAIT;
                end
                S_KP_WAIT:
                begin
                    kp_reg    <= k_rdata_reg;
                    state_reg <= S_SLOT_RD;
                end
                S_SLOT_RD:
                begin
                    state_reg <= S_SLOT_WAIT;
                end
                S_SLOT_WAIT:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (req_reg == REQ_POP)
                    begin
                        pk_reg    <= s_rkey_reg;
                        pw_reg    <= s_rwt_reg;
                        count_reg <= count_reg - CntW'(1);
                        if (count_reg == CntW'(1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_POP_RD_LAST;
                        end
                    end
                    else if (req_reg == REQ_CHANGE && present_w)
                    begin
                        if (cmp_lt)
                        begin
                            pos_reg     <= kp_reg;
                            cur_key_reg <= key_reg;
                            cur_wt_reg  <= wt_reg;
                            state_reg   <= S_UP_WR2;
                        end
                        else
                        begin
                            status_reg <= ST_IGNORED;
                            state_reg  <= S_DONE;
                        end
                    end
                    else if (full_w)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else if (present_w)
                    begin
                        status_reg <= ST_PRESENT;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        pos_reg     <= PosW'(count_reg);
                        cur_key_reg <= key_reg;
                        cur_wt_reg  <= wt_reg;
                        count_reg   <= count_reg + CntW'(1);
                        state_reg   <= S_PUSH_WR;
                    end
                end
                S_PUSH_WR, S_UP_WR2:
                begin
                    // Entry written; try one more level up.
                    if (pos_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_UP_RD:
                begin
                    oth_pos_reg <= PosW'(parent_idx);
                    state_reg   <= S_UP_WAIT;
                end
                S_UP_WAIT:
                begin
                    oth_key_reg <= s_rkey_reg;
                    oth_wt_reg  <= s_rwt_reg;
                    state_reg   <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (cmp_lt)
                    begin
                        pos_reg   <= oth_pos_reg;
                        state_reg <= S_UP_WR2;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_POP_RD_LAST:
                begin
                    state_reg <= S_POP_WAIT_LAST;
                end
                S_POP_WAIT_LAST:
                begin
                    cur_key_reg <= s_rkey_reg;
                    cur_wt_reg  <= s_rwt_reg;
                    pos_reg     <= '0;
                    state_reg   <= S_POP_WR0;
                end
                S_POP_WR0, S_DN_WR2:
                begin
                    best_valid_reg <= 1'b0;
                    if (left_idx < (CntW + 1)'(count_reg))
                    begin
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DN_RDL:
                begin
                    state_reg <= S_DN_WAITL;
                end
                S_DN_WAITL:
                begin
                    if (cmp_lt)
                    begin
                        best_valid_reg <= 1'b1;
                        oth_pos_reg    <= PosW'(left_idx);
                        oth_key_reg    <= s_rkey_reg;
                        oth_wt_reg     <= s_rwt_reg;
                    end
                    if (right_idx < (CntW + 1)'(count_reg))
                    begin
                        state_reg <= S_DN_RDR;
                    end
                    else
                    begin
                        state_reg <= S_DN_CMP;
                    end
                end
                S_DN_RDR:
                begin
                    state_reg <= S_DN_WAITR;
                end
                S_DN_WAITR:
                begin
                    if (cmp_lt)
                    begin
                        best_valid_reg <= 1'b1;
                        oth_pos_reg    <= PosW'(right_idx);
                        oth_key_reg    <= s_rkey_reg;
                        oth_wt_reg     <= s_rwt_reg;
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (best_valid_reg)
                    begin
                        pos_reg   <= oth_pos_reg;
                        state_reg <= S_DN_WR2;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Busy, done and result outputs.
    assign busy                 = (state_reg != S_IDLE) || done_reg;
    assign done                 = done_reg;
    assign result.status        = status_reg;
    assign result.popped_key    = pk_reg;
    assign result.popped_weight = pw_reg;
    assign result.entry_count   = CountW'(count_reg);
    assign result.is_empty      = (count_reg == '0);

endmodule
`default_nettype wire

// ===== rtl/imhq_checker.sv =====
`default_nettype none
module imhq_checker
    import imhq_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // A result is only shown while busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result shown while not busy");

    // An accepted request makes the block busy at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");

    // Empty flag agrees with the count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.entry_count == '0)))
        else $error("empty flag disagrees with count");

    // A result strobe lasts one cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than a cycle");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
